FILE: rtl/endf_number_field_to_double_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef ENDF_NUMBER_FIELD_TO_DOUBLE_UNIT_MACROS_SVH
`define ENDF_NUMBER_FIELD_TO_DOUBLE_UNIT_MACROS_SVH

// Property checked at every rising edge, masked while reset is high.
`define ENDF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("endf assertion failed");

// Property checked at every rising edge, reset included.
`define ENDF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("endf assertion failed");

`endif

FILE: rtl/endf_pkg.sv
package endf_pkg;

   typedef struct packed {
      logic        bad;
      logic        is_int;
      logic        neg;
      logic        neg_exp;
      logic        long_form;
      logic [6:0]  expo;
      logic [33:0] mant;
   } item_type;

   typedef struct packed {
      logic        go;
      logic        is_div;
      logic [63:0] a;
      logic [63:0] b;
   } fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] res;
   } fpu_rsp_type;

   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [63:0] DBL_ONE   = 64'h3FF0000000000000;
   localparam logic [63:0] DBL_1EM6  = 64'h3EB0C6F7A0B5ED8D;
   localparam logic [63:0] DBL_1EM5  = 64'h3EE4F8B588E368F1;

   // 10^(2^k), k = 0..6
   localparam logic [63:0] POW_TBL [7] = '{
      64'h4024000000000000,
      64'h4059000000000000,
      64'h40C3880000000000,
      64'h4197D78400000000,
      64'h4341C37937E08000,
      64'h4693B8B5B5056E17,
      64'h4D384F03E93FF9F5
   };

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_SPACE);
   endfunction

endpackage

FILE: rtl/endf_number_field_to_double_unit.sv
// ENDF 11-character number field to IEEE double. Pulse start with the item
// on req_field_head/req_field_tail while busy is low; the item is taken at
// that edge. Each item yields exactly one result, shown for one cycle with
// rsp_strobe high; the receiver must take it then, there is no back pressure.
// The front scans one character per cycle (busy while it runs and while it
// waits for room in the queue) and hands the classified item to a small
// queue, so a new item can be loaded while the back end is still working on
// the previous one. The back end takes one item at a time: a format error or
// zero value is answered from its check state, an integer is normalized with
// one leading-zero shift per cycle, and a float takes one normalize shift per
// cycle, a walk over the power-of-ten bits, then up to seven double multiplies
// (at most five for the power of ten of a two-digit exponent, then the scale
// and the mantissa) on the shared multiplier (four 27x27 partial products
// each) plus, for a negative exponent, a bit-serial reciprocal (56 quotient
// bits). rsp_format_error flags a non-digit in a digit position, with the
// value then +0.0.
module endf_number_field_to_double_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_field_head,
   input  logic [23:0] req_field_tail,
   output logic        rsp_strobe,
   output logic [63:0] rsp_value_bits,
   output logic        rsp_format_error
);
   import endf_pkg::*;

   logic        push, q_full, q_empty, pop;
   item_type    push_item, pop_item;
   fpu_req_type fpu_req;
   fpu_rsp_type fpu_rsp;

   // parse and classify, one character per cycle
   endf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .field_head (req_field_head),
      .field_tail (req_field_tail),
      .push       (push),
      .push_item  (push_item),
      .q_full     (q_full)
   );

   // decouples front from back
   endf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   // sequencer: normalize, power of ten, reciprocal, scale, final multiply
   endf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_item           (pop_item),
      .pop              (pop),
      .fpu_req          (fpu_req),
      .fpu_rsp          (fpu_rsp),
      .rsp_strobe       (rsp_strobe),
      .rsp_value_bits   (rsp_value_bits),
      .rsp_format_error (rsp_format_error)
   );

   // shared multiplier / reciprocal unit
   endf_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .req   (fpu_req),
      .rsp   (fpu_rsp)
   );

endmodule

FILE: rtl/endf_front.sv
module endf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [63:0]       field_head,
   input  logic [23:0]       field_tail,
   output logic              push,
   output endf_pkg::item_type push_item,
   input  logic              q_full
);
   import endf_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_SCAN = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [33:0] mant_ff, mant_in;
   logic [7:0]  ch_ff [11];
   logic [7:0]  ch_in [11];

   logic        is_float, long_form, bad;
   logic [3:0]  stop;
   logic [10:0] mmask, dmask;
   logic [7:0]  e_wide;

   // field classification from the latched characters
   always_comb begin
      is_float  = (ch_ff[2] == CH_DOT);
      long_form = (ch_ff[9] == CH_PLUS) || (ch_ff[9] == CH_MINUS);
      stop = 4'd0;
      for (int p = 1; p < 10; p++) begin
         if (is_sep(ch_ff[p])) stop = 4'(p);
      end
      mmask = '0;
      if (is_float) begin
         mmask[1] = 1'b1;
         for (int p = 3; p < 8; p++) mmask[p] = 1'b1;
         mmask[8] = long_form;
         dmask = mmask;
         dmask[10] = 1'b1;
         dmask[9]  = ~long_form;
      end else begin
         for (int p = 0; p < 11; p++) begin
            if (4'(p) > stop) mmask[p] = 1'b1;
         end
         dmask = mmask;
      end
      bad = 1'b0;
      for (int p = 0; p < 11; p++) begin
         if (dmask[p] && !is_digit(ch_ff[p])) bad = 1'b1;
      end
      e_wide = {1'b0, ch_ff[9][3:0], 3'b0} + {3'b0, ch_ff[9][3:0], 1'b0}
             + {4'b0, ch_ff[10][3:0]};
   end

   always_comb begin
      push_item.bad       = bad;
      push_item.is_int    = ~is_float;
      push_item.neg       = is_float ? (ch_ff[0] == CH_MINUS) : (ch_ff[stop] == CH_MINUS);
      push_item.neg_exp   = long_form ? (ch_ff[9] == CH_MINUS) : (ch_ff[8] == CH_MINUS);
      push_item.long_form = long_form;
      push_item.expo      = long_form ? {3'b0, ch_ff[10][3:0]} : e_wide[6:0];
      push_item.mant      = mant_ff;
   end

   assign busy = (state_ff != F_IDLE);
   assign push = (state_ff == F_PUSH) && !q_full;

   // one character a cycle, left to right
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mant_in  = mant_ff;
      ch_in    = ch_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               for (int i = 0; i < 8; i++) ch_in[i] = field_head[63 - 8 * i -: 8];
               for (int i = 0; i < 3; i++) ch_in[8 + i] = field_tail[23 - 8 * i -: 8];
               cnt_in   = 4'd0;
               mant_in  = '0;
               state_in = F_SCAN;
            end
         end
         F_SCAN: begin
            if (mmask[cnt_ff]) begin
               mant_in = {mant_ff[30:0], 3'b0} + {mant_ff[32:0], 1'b0}
                       + {30'b0, ch_ff[cnt_ff][3:0]};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd10) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= 4'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      mant_ff <= mant_in;
      ch_ff   <= ch_in;
   end

endmodule

FILE: rtl/endf_queue.sv
module endf_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  endf_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output endf_pkg::item_type pop_item,
   output logic               empty
);
   import endf_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (push && !pop)      cnt_in = cnt_ff + CW'(1);
      else if (pop && !push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_item;
   end

endmodule

FILE: rtl/endf_fpu.sv
// Double multiply and reciprocal for positive normal operands, RNE.
module endf_fpu (
   input  logic                  clock,
   input  logic                  reset,
   input  endf_pkg::fpu_req_type req,
   output endf_pkg::fpu_rsp_type rsp
);
   import endf_pkg::*;

   localparam logic [1:0] U_IDLE = 2'd0;
   localparam logic [1:0] U_MUL  = 2'd1;
   localparam logic [1:0] U_DIV  = 2'd2;
   localparam logic [1:0] U_RND  = 2'd3;

   logic [1:0]   state_ff, state_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         div_ff, div_in;
   logic [52:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic [10:0]  ea_ff, ea_in, eb_ff, eb_in;
   logic [53:0]  pp_ff, pp_in;
   logic [1:0]   sh_ff, sh_in;
   logic [105:0] acc_ff, acc_in;
   logic [54:0]  r_ff, r_in;
   logic [55:0]  q_ff, q_in;
   logic         done_ff, done_in;
   logic [63:0]  res_ff, res_in;

   logic [26:0]  opx, opy;
   logic [105:0] pp_sh;
   logic         ge;
   logic         top, g, s, up;
   logic [52:0]  rm;
   logic [53:0]  m54;
   logic [12:0]  rexp;

   assign rsp.done = done_ff;
   assign rsp.res  = res_ff;

   // partial product operands: low/high halves of each significand
   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin opx = {1'b0, ma_ff[25:0]}; opy = {1'b0, mb_ff[25:0]}; end
         2'd1: begin opx = {1'b0, ma_ff[25:0]}; opy = mb_ff[52:26]; end
         2'd2: begin opx = ma_ff[52:26]; opy = {1'b0, mb_ff[25:0]}; end
         default: begin opx = ma_ff[52:26]; opy = mb_ff[52:26]; end
      endcase
      case (sh_ff) inside
         2'd0:       pp_sh = {52'b0, pp_ff};
         2'd1, 2'd2: pp_sh = {26'b0, pp_ff, 26'b0};
         default:    pp_sh = {pp_ff, 52'b0};
      endcase
      ge = (r_ff >= {2'b0, mb_ff});
   end

   // normalize and round to nearest even
   always_comb begin
      if (!div_ff) begin
         top  = acc_ff[105];
         rm   = top ? acc_ff[105:53] : acc_ff[104:52];
         g    = top ? acc_ff[52] : acc_ff[51];
         s    = top ? (|acc_ff[51:0]) : (|acc_ff[50:0]);
         rexp = {2'b0, ea_ff} + {2'b0, eb_ff} + {12'b0, top} - 13'd1023;
      end else begin
         top  = q_ff[55];
         rm   = top ? q_ff[55:3] : q_ff[54:2];
         g    = top ? q_ff[2] : q_ff[1];
         s    = top ? ((|q_ff[1:0]) | (|r_ff)) : (q_ff[0] | (|r_ff));
         rexp = (top ? 13'd2046 : 13'd2045) - {2'b0, eb_ff};
      end
      up  = g & (s | rm[0]);
      m54 = {1'b0, rm} + {53'b0, up};
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      div_in   = div_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      ea_in    = ea_ff;
      eb_in    = eb_ff;
      pp_in    = pp_ff;
      sh_in    = sh_ff;
      acc_in   = acc_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (req.go) begin
               ma_in    = {1'b1, req.a[51:0]};
               mb_in    = {1'b1, req.b[51:0]};
               ea_in    = req.a[62:52];
               eb_in    = req.b[62:52];
               div_in   = req.is_div;
               cnt_in   = '0;
               acc_in   = '0;
               r_in     = {3'b001, 52'b0};
               q_in     = '0;
               state_in = req.is_div ? U_DIV : U_MUL;
            end
         end
         U_MUL: begin
            if (cnt_ff != 6'd4) begin
               pp_in = opx * opy;
               sh_in = cnt_ff[1:0];
            end
            if (cnt_ff != 6'd0) acc_in = acc_ff + pp_sh;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd4) state_in = U_RND;
         end
         U_DIV: begin
            q_in   = {q_ff[54:0], ge};
            r_in   = ge ? {r_ff - {2'b0, mb_ff}} << 1 : r_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd55) state_in = U_RND;
         end
         U_RND: begin
            if (m54[53]) res_in = {1'b0, 11'(rexp + 13'd1), m54[52:1]};
            else         res_in = {1'b0, rexp[10:0], m54[51:0]};
            done_in  = 1'b1;
            state_in = U_IDLE;
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      div_ff <= div_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      ea_ff  <= ea_in;
      eb_ff  <= eb_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      res_ff <= res_in;
   end

endmodule

FILE: rtl/endf_back.sv
module endf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  endf_pkg::item_type    q_item,
   output logic                  pop,
   output endf_pkg::fpu_req_type fpu_req,
   input  endf_pkg::fpu_rsp_type fpu_rsp,
   output logic                  rsp_strobe,
   output logic [63:0]           rsp_value_bits,
   output logic                  rsp_format_error
);
   import endf_pkg::*;

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_CHECK = 3'd1;
   localparam logic [2:0] B_NORM  = 3'd2;
   localparam logic [2:0] B_POW   = 3'd3;
   localparam logic [2:0] B_WAIT  = 3'd4;

   localparam logic [1:0] PH_POW  = 2'd0;
   localparam logic [1:0] PH_DIV  = 2'd1;
   localparam logic [1:0] PH_SCL  = 2'd2;
   localparam logic [1:0] PH_MANT = 2'd3;

   logic [2:0]  state_ff, state_in;
   item_type    item_ff, item_in;
   logic [33:0] nm_ff, nm_in;
   logic [10:0] nexp_ff, nexp_in;
   logic [63:0] mdbl_ff, mdbl_in;
   logic [63:0] p_ff, p_in;
   logic [2:0]  k_ff, k_in;
   logic [1:0]  ph_ff, ph_in;
   logic        go_ff, go_in, isdiv_ff, isdiv_in;
   logic [63:0] a_ff, a_in, b_ff, b_in;
   logic        strobe_ff, strobe_in, err_ff, err_in;
   logic [63:0] val_ff, val_in;
   logic [63:0] scale;

   assign scale            = item_ff.long_form ? DBL_1EM6 : DBL_1EM5;
   assign pop              = (state_ff == B_IDLE) && !q_empty;
   assign fpu_req.go       = go_ff;
   assign fpu_req.is_div   = isdiv_ff;
   assign fpu_req.a        = a_ff;
   assign fpu_req.b        = b_ff;
   assign rsp_strobe       = strobe_ff;
   assign rsp_value_bits   = val_ff;
   assign rsp_format_error = err_ff;

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      nm_in     = nm_ff;
      nexp_in   = nexp_ff;
      mdbl_in   = mdbl_ff;
      p_in      = p_ff;
      k_in      = k_ff;
      ph_in     = ph_ff;
      go_in     = 1'b0;
      isdiv_in  = isdiv_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      strobe_in = 1'b0;
      err_in    = err_ff;
      val_in    = val_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               item_in  = q_item;
               state_in = B_CHECK;
            end
         end
         B_CHECK: begin
            if (item_ff.bad || item_ff.mant == '0) begin
               strobe_in = 1'b1;
               val_in    = '0;
               err_in    = item_ff.bad;
               state_in  = B_IDLE;
            end else begin
               nm_in    = item_ff.mant;
               nexp_in  = 11'd1056;   // bias + 33
               state_in = B_NORM;
            end
         end
         B_NORM: begin
            if (nm_ff[33]) begin
               if (item_ff.is_int) begin
                  strobe_in = 1'b1;
                  err_in    = 1'b0;
                  val_in    = {item_ff.neg, nexp_ff, nm_ff[32:0], 19'b0};
                  state_in  = B_IDLE;
               end else begin
                  mdbl_in  = {1'b0, nexp_ff, nm_ff[32:0], 19'b0};
                  p_in     = item_ff.expo[0] ? POW_TBL[0] : DBL_ONE;
                  k_in     = 3'd1;
                  state_in = B_POW;
               end
            end else begin
               nm_in   = {nm_ff[32:0], 1'b0};
               nexp_in = nexp_ff - 11'd1;
            end
         end
         B_POW: begin
            if (k_ff == 3'd7) begin
               go_in    = 1'b1;
               isdiv_in = item_ff.neg_exp;
               a_in     = p_ff;
               b_in     = item_ff.neg_exp ? p_ff : scale;
               ph_in    = item_ff.neg_exp ? PH_DIV : PH_SCL;
               state_in = B_WAIT;
            end else begin
               // a factor of 1.0 is exact, so unset bits need no multiply
               if (item_ff.expo[k_ff]) begin
                  go_in    = 1'b1;
                  isdiv_in = 1'b0;
                  a_in     = p_ff;
                  b_in     = POW_TBL[k_ff];
                  ph_in    = PH_POW;
                  state_in = B_WAIT;
               end
               k_in = k_ff + 3'd1;
            end
         end
         B_WAIT: begin
            if (fpu_rsp.done) begin
               p_in = fpu_rsp.res;
               unique case (ph_ff)
                  PH_POW: state_in = B_POW;
                  PH_DIV: begin
                     go_in    = 1'b1;
                     isdiv_in = 1'b0;
                     a_in     = fpu_rsp.res;
                     b_in     = scale;
                     ph_in    = PH_SCL;
                  end
                  PH_SCL: begin
                     go_in    = 1'b1;
                     isdiv_in = 1'b0;
                     a_in     = fpu_rsp.res;
                     b_in     = mdbl_ff;
                     ph_in    = PH_MANT;
                  end
                  PH_MANT: begin
                     strobe_in = 1'b1;
                     err_in    = 1'b0;
                     val_in    = {item_ff.neg, fpu_rsp.res[62:0]};
                     state_in  = B_IDLE;
                  end
                  default: state_in = B_IDLE;
               endcase
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         go_ff     <= 1'b0;
         strobe_ff <= 1'b0;
         err_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         go_ff     <= go_in;
         strobe_ff <= strobe_in;
         err_ff    <= err_in;
      end
      item_ff  <= item_in;
      nm_ff    <= nm_in;
      nexp_ff  <= nexp_in;
      mdbl_ff  <= mdbl_in;
      p_ff     <= p_in;
      k_ff     <= k_in;
      ph_ff    <= ph_in;
      isdiv_ff <= isdiv_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      val_ff   <= val_in;
   end

endmodule

FILE: rtl/endf_chk.sv
`include "endf_number_field_to_double_unit_macros.svh"

module endf_chk (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [63:0] rsp_value_bits,
   input logic        rsp_format_error
);

   `ENDF_ASSERT(a_err_zero, clock, reset, rsp_strobe && rsp_format_error |-> rsp_value_bits == 64'd0)
   `ENDF_ASSERT(a_accept_busy, clock, reset, start && !busy |=> busy)
   `ENDF_ASSERT(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe)
   `ENDF_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_strobe && !busy)

endmodule

bind endf_number_field_to_double_unit endf_chk u_chk (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_value_bits   (rsp_value_bits),
   .rsp_format_error (rsp_format_error)
);

FILE: tb/tb_endf_number_field_to_double_unit.sv
`timescale 1ns / 100ps

module tb_endf_number_field_to_double_unit;
   import endf_pkg::*;

   typedef logic [7:0] field_chars_type [11];

   typedef struct {
      logic [63:0] head;
      logic [23:0] tail;
   } field_item_type;

   typedef struct {
      logic [63:0] bits;
      logic        err;
   } parsed_value_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_field_head;
   logic [23:0] req_field_tail;
   logic        rsp_strobe;
   logic [63:0] rsp_value_bits;
   logic        rsp_format_error;

   // fields waiting to be sent, and parsed values waiting on the result port
   field_item_type   fields_to_send [$];
   parsed_value_type values_due [$];

   int sender_idle_pct = 0;
   int n_sent          = 0;
   int n_checked       = 0;
   int n_float         = 0;
   int n_int           = 0;
   int n_bad           = 0;
   int n_fail          = 0;

   endf_number_field_to_double_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_field_head   (req_field_head),
      .req_field_tail   (req_field_tail),
      .rsp_strobe       (rsp_strobe),
      .rsp_value_bits   (rsp_value_bits),
      .rsp_format_error (rsp_format_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: same operation order as the field parser, all in doubles,
   // so every multiply and the reciprocal round exactly like the block.
   // ---------------------------------------------------------------------
   function automatic logic digit_ok(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic real pow_of_ten(int unsigned e);
      real f [7];
      real p;
      f = '{10.0, 100.0, 1.0e4, 1.0e8, 1.0e16, 1.0e32, 1.0e64};
      p = e[0] ? f[0] : 1.0;
      for (int k = 1; k < 7; k++)
         p = p * (e[k] ? f[k] : 1.0);
      return p;
   endfunction

   function automatic parsed_value_type parse_field(logic [63:0] head, logic [23:0] tail);
      field_chars_type  ch;
      parsed_value_type r;
      logic             bad;
      logic             long_form;
      logic             neg_exp;
      longint           mant;
      longint           place;
      int unsigned      e;
      int               pos;
      real              scale;
      real              v;
      bad = 1'b0;
      v   = 0.0;
      for (int i = 0; i < 8; i++) ch[i] = head[8*(7-i) +: 8];
      for (int i = 0; i < 3; i++) ch[8+i] = tail[8*(2-i) +: 8];
      mant = 0;
      if (ch[2] == CH_DOT) begin
         long_form = (ch[9] == CH_PLUS) || (ch[9] == CH_MINUS);
         // mantissa digits: char 1 then chars 3.. (6 more or 5 more)
         for (int i = 0; i < (long_form ? 7 : 6); i++) begin
            pos = (i == 0) ? 1 : i + 2;
            if (!digit_ok(ch[pos])) bad = 1'b1;
            mant = mant * 10 + longint'(ch[pos][3:0]);
         end
         if (long_form) begin
            if (!digit_ok(ch[10])) bad = 1'b1;
            e       = ch[10][3:0];
            neg_exp = (ch[9] == CH_MINUS);
         end else begin
            if (!digit_ok(ch[9]) || !digit_ok(ch[10])) bad = 1'b1;
            e       = ch[9][3:0] * 10 + ch[10][3:0];
            neg_exp = (ch[8] == CH_MINUS);
         end
         if (!bad) begin
            scale = pow_of_ten(e);
            if (neg_exp) scale = 1.0 / scale;
            scale = scale * (long_form ? 1.0e-6 : 1.0e-5);
            if (ch[0] == CH_MINUS) mant = -mant;
            v = real'(mant) * scale;
         end
      end else begin
         // integer: units at char 10, scan left until a separator or char 0
         if (!digit_ok(ch[10])) bad = 1'b1;
         mant  = ch[10][3:0];
         place = 10;
         pos   = 9;
         while (ch[pos] != CH_MINUS && ch[pos] != CH_PLUS && ch[pos] != CH_SPACE
                && pos > 0) begin
            if (!digit_ok(ch[pos])) bad = 1'b1;
            mant  = mant + place * longint'(ch[pos][3:0]);
            place = place * 10;
            pos--;
         end
         if (!bad) begin
            if (ch[pos] == CH_MINUS) mant = -mant;
            v = real'(mant);
         end
      end
      if (bad) v = 0.0;
      r.bits = $realtobits(v);
      r.err  = bad;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Field builders
   // ---------------------------------------------------------------------
   function automatic logic [7:0] rand_digit();
      return 8'h30 + 8'($urandom_range(9));
   endfunction

   // any byte outside '0'..'9', high-bit bytes included
   function automatic logic [7:0] rand_non_digit();
      logic [7:0] c;
      do c = 8'($urandom); while (digit_ok(c));
      return c;
   endfunction

   function automatic logic [7:0] rand_sign();
      case ($urandom_range(3))
         0: return CH_MINUS;
         1: return CH_PLUS;
         2: return CH_SPACE;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic queue_chars(field_chars_type ch);
      field_item_type it;
      for (int i = 0; i < 8; i++) it.head[8*(7-i) +: 8] = ch[i];
      for (int i = 0; i < 3; i++) it.tail[8*(2-i) +: 8] = ch[8+i];
      fields_to_send.push_back(it);
   endtask

   // float field; corrupt != 0 breaks one digit position
   task automatic queue_float(logic long_form, logic corrupt);
      field_chars_type ch;
      int              p;
      ch[0] = rand_sign();
      ch[1] = rand_digit();
      ch[2] = CH_DOT;
      for (int i = 3; i <= 10; i++) ch[i] = rand_digit();
      if (long_form) ch[9] = $urandom_range(1) ? CH_MINUS : CH_PLUS;
      else           ch[8] = rand_sign();
      // a zero last exponent digit now and then (a zero exponent in long form)
      if ($urandom_range(7) == 0) ch[10] = "0";
      if (corrupt) begin
         do p = $urandom_range(10); while (p == 0 || p == 2 || (long_form && p == 9)
                                           || (!long_form && p == 8));
         do ch[p] = rand_non_digit();
         while (!long_form && p == 9 && (ch[p] == CH_PLUS || ch[p] == CH_MINUS));
      end
      queue_chars(ch);
   endtask

   // integer with ndig digits, separator sep in front of them
   task automatic queue_int(int ndig, logic [7:0] sep, logic corrupt);
      field_chars_type ch;
      for (int i = 0; i < 11; i++) ch[i] = $urandom_range(1) ? CH_SPACE : 8'($urandom);
      for (int i = 0; i < ndig; i++) ch[10-i] = rand_digit();
      if (ndig < 11) ch[10-ndig] = sep;
      if (ch[2] == CH_DOT) ch[2] = CH_SPACE;
      if (corrupt) ch[10 - $urandom_range(ndig - 1)] = rand_non_digit();
      queue_chars(ch);
   endtask

   task automatic queue_random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30)      queue_float(1'b1, $urandom_range(9) == 0);
      else if (pick < 60) queue_float(1'b0, $urandom_range(9) == 0);
      else if (pick < 90) queue_int($urandom_range(1, 10), rand_sign(), $urandom_range(9) == 0);
      else begin
         field_item_type it;
         it.head = {$urandom, $urandom};
         it.tail = 24'($urandom);
         fields_to_send.push_back(it);
      end
   endtask

   task automatic wait_drained();
      while (fields_to_send.size() != 0 || values_due.size() != 0 || start)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Driver: start rises only when a field is pending and the idle draw
   // passes; the accepted field is the one on the ports at that edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start          <= 1'b0;
         req_field_head <= '0;
         req_field_tail <= '0;
      end else begin
         if (start && !busy) begin
            parsed_value_type pv;
            pv = parse_field(req_field_head, req_field_tail);
            values_due.push_back(pv);
            fields_to_send.delete(0);
            n_sent++;
            if (pv.err) n_bad++;
            else if (req_field_head[47:40] == CH_DOT) n_float++;
            else n_int++;
         end
         if (fields_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            start          <= 1'b1;
            req_field_head <= fields_to_send[0].head;
            req_field_tail <= fields_to_send[0].tail;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe must match the oldest outstanding field.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (values_due.size() == 0) begin
            $display("%0t: unexpected result bits=%h err=%b", $time,
                     rsp_value_bits, rsp_format_error);
            n_fail++;
         end else begin
            if (rsp_value_bits !== values_due[0].bits) begin
               $display("%0t: value_bits expected %h actual %h", $time,
                        values_due[0].bits, rsp_value_bits);
               n_fail++;
            end
            if (rsp_format_error !== values_due[0].err) begin
               $display("%0t: format_error expected %b actual %b", $time,
                        values_due[0].err, rsp_format_error);
               n_fail++;
            end
            values_due.delete(0);
            n_checked++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus phases
   // ---------------------------------------------------------------------
   initial begin
      int phase_idle [4];
      reset          = 1'b1;
      start          = 1'b0;
      req_field_head = '0;
      req_field_tail = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes and the named corner cases
      queue_chars('{"-", "9", ".", "9", "9", "9", "9", "9", "9", "+", "9"}); // long, max exp
      queue_chars('{" ", "1", ".", "0", "0", "0", "0", "0", "0", "-", "9"}); // long, neg exp
      queue_chars('{" ", "9", ".", "9", "9", "9", "9", "9", "+", "9", "9"}); // short, exp 99
      queue_chars('{"-", "1", ".", "0", "0", "0", "0", "0", "-", "9", "9"}); // short, exp -99
      queue_chars('{"-", "0", ".", "0", "0", "0", "0", "0", "0", "+", "0"}); // minus zero
      queue_chars('{"-", "0", ".", "0", "0", "0", "0", "0", " ", "0", "0"}); // minus zero, short
      queue_chars('{" ", "1", ".", "2", "3", "4", "5", "6", "x", "0", "5"}); // odd exp sign
      queue_chars('{" ", " ", " ", " ", " ", " ", " ", " ", " ", " ", " "}); // blank field
      queue_chars('{" ", " ", " ", " ", " ", " ", " ", " ", " ", " ", "0"});
      queue_chars('{"x", "9", "9", "9", "9", "9", "9", "9", "9", "9", "9"}); // ten digits
      queue_chars('{"-", "9", "9", "9", "9", "9", "9", "9", "9", "9", "9"});
      queue_chars('{" ", " ", " ", " ", " ", " ", " ", " ", "-", "4", "2"}); // neg int
      queue_chars('{" ", " ", " ", " ", " ", " ", " ", "+", "1", "2", "3"});
      queue_chars('{" ", " ", " ", " ", " ", " ", " ", " ", "1", "a", "3"}); // bad int digit
      queue_chars('{" ", "1", ".", "2", "3", 8'hB4, "5", "6", "7", "+", "1"}); // high-bit byte
      queue_chars('{" ", "1", ".", "2", "3", "4", "5", "6", "-", "0", "?"}); // bad exp digit
      queue_chars('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'hFF, 8'hFF, 8'hFF});
      queue_chars('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00});
      wait_drained(); // sender holds off until every result is back

      // random phases: no idling, sender idle 71, receiver phase (no stall
      // possible, so no idling), then 22
      phase_idle = '{0, 71, 0, 22};
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct = phase_idle[ph];
         repeat (100) queue_random_item();
         wait_drained();
      end

      repeat (200) @(posedge clock);
      $display("Checked %0d of %0d fields: %0d floats, %0d integers, %0d format errors",
               n_checked, n_sent, n_float, n_int, n_bad);
      $display("Sender idle rates 0/71/22 percent; directed corner fields included.");
      if (n_fail == 0 && values_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
